// ===== design/edf_pkg.sv =====
// Package for the Ethernet destination address filter.
// Holds the address type, the class codes and the address pattern constants.
// No dependencies.
package edf_pkg;

  typedef logic [47:0] mac_addr_t;
  typedef logic [3:0]  addr_class_t;

  localparam addr_class_t CLS_REJECT  = 4'd0;
  localparam addr_class_t CLS_UNICAST = 4'd1;
  localparam addr_class_t CLS_BCAST   = 4'd2;
  localparam addr_class_t CLS_NODES   = 4'd3;
  localparam addr_class_t CLS_ROUTERS = 4'd4;
  localparam addr_class_t CLS_MDNS    = 4'd5;
  localparam addr_class_t CLS_LLMNR   = 4'd6;
  localparam addr_class_t CLS_NTP     = 4'd7;
  localparam addr_class_t CLS_SOLICIT = 4'd8;

  localparam logic [7:0] BYTE_BCAST = 8'hFF;
  localparam logic [7:0] BYTE_MC4   = 8'h01;
  localparam logic [7:0] BYTE_MC6   = 8'h33;
  localparam logic [7:0] BYTE_SOL   = 8'hFF;

  localparam logic [31:0] MC4_PREFIX = 32'h01005E00;

  localparam logic [15:0] MC4_NODES   = 16'h0001;
  localparam logic [15:0] MC4_ROUTERS = 16'h0002;
  localparam logic [15:0] MC4_MDNS    = 16'h00FB;
  localparam logic [15:0] MC4_LLMNR   = 16'h00FC;
  localparam logic [15:0] MC4_NTP     = 16'h0101;

  localparam mac_addr_t MC6_NODES   = 48'h333300000001;
  localparam mac_addr_t MC6_ROUTERS = 48'h333300000002;
  localparam mac_addr_t MC6_MDNS    = 48'h3333000000FB;
  localparam mac_addr_t MC6_NTP     = 48'h333300000101;
  localparam mac_addr_t MC6_LLMNR   = 48'h333300010003;

endpackage

// ===== design/edf_if.sv =====
// Stream interfaces of the destination address filter: address in, class out.
// Each carries valid, ready and the payload. Depends on edf_pkg.
interface edf_addr_if
  import edf_pkg::*;
();
  logic      valid;
  logic      ready;
  mac_addr_t dest_address;

  modport source (output valid, output dest_address, input ready);
  modport sink (input valid, input dest_address, output ready);
endinterface

interface edf_class_if
  import edf_pkg::*;
();
  logic        valid;
  logic        ready;
  addr_class_t address_class;

  modport source (output valid, output address_class, input ready);
  modport sink (input valid, input address_class, output ready);
endinterface

// ===== design/ethernet_destination_filter.sv =====
// Top level of the Ethernet destination address filter.
// Holds the local address register, the input and result registers.
// Depends on edf_pkg, edf_if and edf_classifier.
//
// One destination address is taken per cycle while the input is not stalled. Its
// class is on the result port once the input register and the result register
// around the classifier have both loaded. Throughput is
// one address per clock whenever the result side keeps ready high. While a
// result waits on a stalled output, one more address can still enter the input
// register; after that the input stalls until the result is taken. The local
// address is written through cfg_write_enable/cfg_write_data and takes effect
// for addresses classified after the write; it resets to zero.
module ethernet_destination_filter
  import edf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_enable,
  input  mac_addr_t      cfg_write_data,
  edf_addr_if.sink       dest,
  edf_class_if.source    result
);

  mac_addr_t   local_address;
  logic        in_valid;
  mac_addr_t   in_address;
  logic        out_valid;
  addr_class_t out_class;
  addr_class_t class_next;
  logic        out_advance;
  logic        in_advance;

  assign out_advance = !out_valid || result.ready;
  assign in_advance  = !in_valid || out_advance;
  assign dest.ready  = in_advance;

  edf_classifier u_classifier (
    .address       (in_address),
    .local_address (local_address),
    .address_class (class_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
    end else if (cfg_write_enable) begin
      local_address <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_advance) begin
      in_valid <= dest.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && dest.valid) begin
      in_address <= dest.dest_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      out_class <= class_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.address_class = out_class;

`ifndef SYNTHESIS
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_class <= CLS_SOLICIT)
    else $error("result class code out of range");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_advance |=> out_valid)
    else $error("classified address lost between stages");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_advance |=> in_valid && $stable(in_address))
    else $error("input stage changed while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_class))
    else $error("result changed while stalled");
`endif

endmodule

// ===== design/edf_classifier.sv =====
// Combinational classifier: sorts one destination address into its class.
// Depends on edf_pkg.
module edf_classifier
  import edf_pkg::*;
(
  input  mac_addr_t   address,
  input  mac_addr_t   local_address,
  output addr_class_t address_class
);

  always_comb begin
    address_class = CLS_REJECT;
    case (address[47:40])
      BYTE_BCAST: begin
        if (address == '1) address_class = CLS_BCAST;
      end
      BYTE_MC4: begin
        if (address[47:16] == MC4_PREFIX) begin
          case (address[15:0])
            MC4_NODES:   address_class = CLS_NODES;
            MC4_ROUTERS: address_class = CLS_ROUTERS;
            MC4_MDNS:    address_class = CLS_MDNS;
            MC4_LLMNR:   address_class = CLS_LLMNR;
            MC4_NTP:     address_class = CLS_NTP;
            default:     address_class = CLS_REJECT;
          endcase
        end
      end
      BYTE_MC6: begin
        if (address[39:32] == BYTE_MC6) begin
          if (address[31:24] == BYTE_SOL) begin
            if (address[23:0] == local_address[23:0]) address_class = CLS_SOLICIT;
          end else if (address == MC6_NODES) begin
            address_class = CLS_NODES;
          end else if (address == MC6_ROUTERS) begin
            address_class = CLS_ROUTERS;
          end else if (address == MC6_MDNS) begin
            address_class = CLS_MDNS;
          end else if (address == MC6_NTP) begin
            address_class = CLS_NTP;
          end else if (address == MC6_LLMNR) begin
            address_class = CLS_LLMNR;
          end
        end
      end
      default: begin
        if (address == local_address) address_class = CLS_UNICAST;
      end
    endcase
  end

endmodule

// ===== tb/edf_result_checker.sv =====
// Result checker for the Ethernet destination address filter testbench.
// Watches the address, class and register-write ports, predicts each class
// and compares it in order. Depends on edf_pkg.
module edf_result_checker
  import edf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  mac_addr_t   cfg_write_data,
  input  logic        addr_valid,
  input  logic        addr_ready,
  input  mac_addr_t   dest_address,
  input  logic        class_valid,
  input  logic        class_ready,
  input  addr_class_t address_class,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    mac_addr_t   addr;
    addr_class_t cls;
  } class_entry_t;

  mac_addr_t    station_addr;
  class_entry_t class_expected[$];
  class_entry_t oldest;

  function automatic addr_class_t classify_dest(mac_addr_t a, mac_addr_t station);
    logic [7:0] lead;
    lead = a[47:40];
    if (lead == BYTE_BCAST)
      return (a == '1) ? CLS_BCAST : CLS_REJECT;
    if (lead == BYTE_MC4) begin
      if (a[47:16] != MC4_PREFIX)
        return CLS_REJECT;
      case (a[15:0])
        MC4_NODES:   return CLS_NODES;
        MC4_ROUTERS: return CLS_ROUTERS;
        MC4_MDNS:    return CLS_MDNS;
        MC4_LLMNR:   return CLS_LLMNR;
        MC4_NTP:     return CLS_NTP;
        default:     return CLS_REJECT;
      endcase
    end
    if (lead == BYTE_MC6) begin
      if (a[39:32] != BYTE_MC6)
        return CLS_REJECT;
      if (a[31:24] == BYTE_SOL)
        return (a[23:0] == station[23:0]) ? CLS_SOLICIT : CLS_REJECT;
      case (a)
        MC6_NODES:   return CLS_NODES;
        MC6_ROUTERS: return CLS_ROUTERS;
        MC6_MDNS:    return CLS_MDNS;
        MC6_NTP:     return CLS_NTP;
        MC6_LLMNR:   return CLS_LLMNR;
        default:     return CLS_REJECT;
      endcase
    end
    return (a == station) ? CLS_UNICAST : CLS_REJECT;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      station_addr = '0;
      class_expected.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (class_valid && class_ready) begin
        if (class_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected class transfer %0d with nothing pending at %0t",
                     address_class, $realtime);
        end else begin
          oldest = class_expected.pop_front();
          checked++;
          if (oldest.cls != address_class) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch for address %012h: expected class %0d, got %0d",
                       oldest.addr, oldest.cls, address_class);
          end
        end
      end
      if (addr_valid && addr_ready)
        class_expected.push_back('{dest_address, classify_dest(dest_address, station_addr)});
      if (cfg_write_enable)
        station_addr = cfg_write_data;
    end
    pending = class_expected.size();
  end

endmodule

// ===== tb/ethernet_destination_filter_test.sv =====
// Top of the Ethernet destination address filter testbench: clock, reset,
// address stimulus, output stalls and verdict. Depends on edf_pkg, edf_if,
// ethernet_destination_filter and edf_result_checker.
module ethernet_destination_filter_test
  import edf_pkg::*;
;

  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_SETTINGS = 5;
  localparam int ITEMS_PER_SET   = 120;
  localparam int CALM_ITEMS      = 80;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write_enable = 1'b0;
  mac_addr_t cfg_write_data = '0;

  edf_addr_if  dest_ch();
  edf_class_if result_ch();

  int        fail_count;
  int        pending;
  int        checked;
  int        sent = 0;
  int        settings = 0;
  int        idle_cycles = 0;
  bit        stalls_on = 1'b1;
  mac_addr_t station = '0;

  always #4 clk = ~clk;

  ethernet_destination_filter u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .dest             (dest_ch),
    .result           (result_ch)
  );

  edf_result_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .addr_valid       (dest_ch.valid),
    .addr_ready       (dest_ch.ready),
    .dest_address     (dest_ch.dest_address),
    .class_valid      (result_ch.valid),
    .class_ready      (result_ch.ready),
    .address_class    (result_ch.address_class),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    int n;
    result_ch.ready = 1'b1;
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        result_ch.ready = 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        result_ch.ready = 1'b1;
        n = $urandom_range(1, 16);
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((dest_ch.valid && dest_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    dest_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_station(input mac_addr_t value);
    wait_drained();
    cfg_write_enable = 1'b1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_enable = 1'b0;
    station = value;
    settings++;
  endtask

  task automatic send_addr(input mac_addr_t a);
    int gap;
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      dest_ch.valid = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    dest_ch.valid = 1'b1;
    dest_ch.dest_address = a;
    @(posedge clk);
    while (!dest_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic mac_addr_t pick_addr(mac_addr_t st);
    mac_addr_t a;
    int        k;
    a = 48'({$urandom, $urandom});
    k = $urandom_range(0, 47);
    case ($urandom_range(0, 9))
      0: a = st;
      1: begin
        a = st;
        a[k] = ~a[k];
      end
      2: begin
        a[47:40] = BYTE_BCAST;
        if ($urandom_range(0, 1) == 0)
          a = '1;
      end
      3: begin
        a[47:16] = MC4_PREFIX;
        case ($urandom_range(0, 5))
          0: a[15:0] = MC4_NODES;
          1: a[15:0] = MC4_ROUTERS;
          2: a[15:0] = MC4_MDNS;
          3: a[15:0] = MC4_LLMNR;
          4: a[15:0] = MC4_NTP;
          default: ;
        endcase
        if ($urandom_range(0, 5) == 0) begin
          k = $urandom_range(0, 39);
          a[k] = ~a[k];
        end
      end
      4: begin
        case ($urandom_range(0, 5))
          0: a = MC6_NODES;
          1: a = MC6_ROUTERS;
          2: a = MC6_MDNS;
          3: a = MC6_NTP;
          4: a = MC6_LLMNR;
          default: a[47:32] = {BYTE_MC6, BYTE_MC6};
        endcase
        if ($urandom_range(0, 5) == 0) begin
          k = $urandom_range(0, 39);
          a[k] = ~a[k];
        end
      end
      5: begin
        a = {BYTE_MC6, BYTE_MC6, BYTE_SOL, st[23:0]};
        if ($urandom_range(0, 3) == 0) begin
          a[k] = ~a[k];
        end
      end
      6: a[47:40] = ($urandom_range(0, 1) == 0) ? BYTE_MC6 : BYTE_MC4;
      7: a = {a[47:40], st[39:0]};
      default: ;
    endcase
    return a;
  endfunction

  initial begin
    dest_ch.valid = 1'b0;
    dest_ch.dest_address = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // local address at its reset value of zero
    send_addr(48'h000000000000);
    send_addr(48'hFFFFFFFFFFFF);
    send_addr(48'h000000000001);

    write_station(48'h021A2B3C4D5E);
    send_addr(station);
    send_addr(station ^ 48'h1);
    send_addr(48'hFFFFFFFFFFFE);
    send_addr({MC4_PREFIX, MC4_NODES});
    send_addr({MC4_PREFIX, MC4_ROUTERS});
    send_addr({MC4_PREFIX, MC4_MDNS});
    send_addr({MC4_PREFIX, MC4_LLMNR});
    send_addr({MC4_PREFIX, MC4_NTP});
    send_addr({MC4_PREFIX, 16'h0003});
    send_addr(48'h01005F000001);
    send_addr(MC6_NODES);
    send_addr(MC6_ROUTERS);
    send_addr(MC6_MDNS);
    send_addr(MC6_NTP);
    send_addr(MC6_LLMNR);
    send_addr(48'h3333000000FC);
    send_addr({BYTE_MC6, BYTE_MC6, BYTE_SOL, station[23:0]});
    send_addr({BYTE_MC6, BYTE_MC6, BYTE_SOL, station[23:0] ^ 24'h1});
    send_addr({BYTE_MC6, 8'h34, BYTE_SOL, station[23:0]});

    // own address inside a multicast family is still rejected
    write_station({MC4_PREFIX, 16'h0009});
    send_addr(station);

    write_station('1);
    send_addr('1);
    send_addr({BYTE_MC6, BYTE_MC6, BYTE_SOL, 24'hFFFFFF});

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      case (s)
        1: write_station('0);
        2: write_station('1);
        3: write_station({BYTE_MC6, 8'($urandom), 32'($urandom)});
        default: write_station({16'($urandom), 32'($urandom)});
      endcase
      for (int i = 0; i < ITEMS_PER_SET; i++)
        send_addr(pick_addr(station));
    end

    write_station({16'($urandom), 32'($urandom)});
    stalls_on = 1'b0;
    for (int i = 0; i < CALM_ITEMS; i++)
      send_addr(pick_addr(station));

    wait_drained();
    $display("Summary: %0d addresses over %0d local address settings, %0d classes compared",
             sent, settings, checked);
    $display("Covered broadcast, IPv4 and IPv6 groups, solicited node, unicast and rejects");
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/edf_pkg.sv
design/edf_if.sv
design/edf_classifier.sv
design/ethernet_destination_filter.sv
tb/edf_result_checker.sv
tb/ethernet_destination_filter_test.sv
